@@ rtl/dphg_pkg.sv @@
// Shared widths, constants and record type of the detector plane hit grouper.
package dphg_pkg;

  localparam int Z_W         = 32;
  localparam int HIT_E_W     = 24;
  localparam int PLANE_E_W   = 32;
  localparam int TOT_E_W     = 40;
  localparam int OUT_CNT_W   = 13;
  localparam int EXCL_W      = 5;
  localparam int TOL_W       = 31;
  localparam int PIECE_W     = 30;

  localparam int IN_W        = 56;
  localparam int OUT_W       = 176;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 31;

  localparam logic [TOL_W-1:0]   TOL_RESET   = 31'd16;
  localparam logic [PIECE_W-1:0] PIECE_RESET = 30'd1024;

  // Early gap limit: 21 for big events, else floor(2n/5) + 1.
  localparam int CHECK_BIG_EVENT = 50;
  localparam int CHECK_CAP       = 21;
  localparam int LIMIT_NUM       = 2;
  localparam int LIMIT_DEN       = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_TOLERANCE = 1'b0,
    REG_PIECE_LENGTH    = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                   record_kind;
    logic [OUT_CNT_W-1:0]   plane_hits;
    logic [PLANE_E_W-1:0]   plane_energy;
    logic [Z_W-1:0]         plane_z;
    logic [OUT_CNT_W-1:0]   total_hits;
    logic [OUT_CNT_W-1:0]   plane_count;
    logic [TOT_E_W-1:0]     total_energy;
    logic [OUT_CNT_W-1:0]   pre_gap_hits;
    logic [EXCL_W-1:0]      excluded_planes;
    logic [OUT_CNT_W-1:0]   trailing_single_planes;
    logic                   all_single;
    logic                   last;
  } record_t;

endpackage

@@ rtl/detector_plane_hit_grouper_core.sv @@
// Top level of the detector plane hit grouper: groups z-ordered hits into planes.
//
// Hits enter on the s_axis channel, one per item, with s_axis_tlast marking the
// last hit of an event. Results leave on the m_axis channel: a plane record
// (tuser 0) for each closed plane and, after the last hit, one summary record
// (tuser 1, tlast 1). Registers are written through the cfg channel, which is
// always ready; write them only while the block is idle.
// A hit is taken while the block is in PH_HIT and the queue has space: the join
// decision, the close of the previous plane and all running sums are done between
// the state registers and a two-entry output queue. A plane record is registered
// into the queue by the hit that closes it. A hit that ends an event holds s_axis
// through the PH_CLOSE and PH_SUM states, in which the last plane record and the
// summary are pushed, each once the queue has space. The queue takes one record
// per cycle while it has space.
// When m_axis stalls, the queue keeps up to two records and s_axis_tready
// drops once it is full. Reset clears the event state, empties the queue and
// loads plane_tolerance = 16 and piece_length = 1024.
module detector_plane_hit_grouper_core #(
  parameter int MAX_HITS = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // hit_z, hit_energy
  input  logic [dphg_pkg::IN_W-1:0]      s_axis_tdata,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // plane_hits, plane_energy, plane_z, total_hits, plane_count, total_energy,
  // pre_gap_hits, excluded_planes, trailing_single_planes, all_single
  output logic [dphg_pkg::OUT_W-1:0]     m_axis_tdata,
  // record_kind
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dphg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dphg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dphg_pkg::*;

  localparam int CNT_W   = $clog2(MAX_HITS + 1);
  localparam int SCALE_W = CNT_W + 3;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_HITS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  typedef enum logic [1:0] {PH_HIT, PH_CLOSE, PH_SUM} phase_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, CNT_MAX}) ? CNT_MAX : s[CNT_W-1:0];
  endfunction

  logic [TOL_W-1:0]   tol;
  logic [PIECE_W-1:0] piece;

  phase_t               phase, phase_next;
  logic                 event_open, event_open_next;
  logic [CNT_W-1:0]     open_hits, open_hits_next;
  logic [PLANE_E_W-1:0] open_energy, open_energy_next;
  logic [Z_W-1:0]       open_z, open_z_next;
  logic [Z_W-1:0]       prev_z, prev_z_next;
  logic [CNT_W-1:0]     closed_planes, closed_planes_next;
  logic [CNT_W-1:0]     hits_so_far, hits_so_far_next;
  logic [TOT_E_W-1:0]   energy_so_far, energy_so_far_next;
  logic [CNT_W-1:0]     single_run, single_run_next;
  logic                 gap_seen, gap_seen_next;
  logic [CNT_W-1:0]     gap_plane, gap_plane_next;
  logic [CNT_W-1:0]     hits_before_gap, hits_before_gap_next;

  record_t     q [2];
  logic        head, tail;
  logic [1:0]  count;
  logic        push, pop, space;
  record_t     push_rec;

  logic [Z_W-1:0]      hit_z;
  logic [HIT_E_W-1:0]  hit_energy;
  logic                in_fire, joins;
  logic [Z_W+1:0]      join_limit;
  logic [PLANE_E_W:0]  plane_sum;
  logic [Z_W:0]        z_diff, z_dist;
  logic                gap_found;
  logic [TOT_E_W:0]    total_sum;
  logic [SCALE_W-1:0]  gap_scaled, count_scaled, n_wide, gap_wide;
  logic                excl;
  record_t             close_rec, sum_rec;

  assign hit_z      = s_axis_tdata[Z_W-1:0];
  assign hit_energy = s_axis_tdata[Z_W +: HIT_E_W];

  assign space         = (count != 2'd2);
  assign s_axis_tready = (phase == PH_HIT) && space;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  assign join_limit = {{2{open_z[Z_W-1]}}, open_z} + {3'b000, tol};
  assign joins = event_open &&
                 ($signed({{2{hit_z[Z_W-1]}}, hit_z}) <= $signed(join_limit));
  assign plane_sum = {1'b0, open_energy} + (PLANE_E_W + 1)'(hit_energy);

  assign z_diff    = {open_z[Z_W-1], open_z} - {prev_z[Z_W-1], prev_z};
  assign z_dist    = z_diff[Z_W] ? (~z_diff + 1'b1) : z_diff;
  assign gap_found = (closed_planes != '0) && !gap_seen &&
                     (z_dist > {2'b00, piece, 1'b0});
  assign total_sum = {1'b0, energy_so_far} + (TOT_E_W + 1)'(open_energy);

  assign n_wide       = SCALE_W'(closed_planes);
  assign gap_wide     = SCALE_W'(gap_plane);
  assign gap_scaled   = gap_wide * SCALE_W'(LIMIT_DEN);
  assign count_scaled = n_wide * SCALE_W'(LIMIT_NUM);
  assign excl = gap_seen &&
                ((n_wide >= SCALE_W'(CHECK_BIG_EVENT)) ? (gap_wide < SCALE_W'(CHECK_CAP))
                                                      : (gap_scaled <= count_scaled));

  always_comb begin
    close_rec              = '0;
    close_rec.plane_hits   = OUT_CNT_W'(open_hits);
    close_rec.plane_energy = open_energy;
    close_rec.plane_z      = open_z;

    sum_rec                        = '0;
    sum_rec.record_kind            = 1'b1;
    sum_rec.total_hits             = OUT_CNT_W'(hits_so_far);
    sum_rec.plane_count            = OUT_CNT_W'(closed_planes);
    sum_rec.total_energy           = energy_so_far;
    sum_rec.pre_gap_hits           = excl ? OUT_CNT_W'(hits_before_gap) : '0;
    sum_rec.excluded_planes        = excl ? EXCL_W'(gap_plane) : '0;
    sum_rec.trailing_single_planes = OUT_CNT_W'(single_run);
    sum_rec.all_single             = (hits_so_far == closed_planes);
    sum_rec.last                   = 1'b1;
  end

  always_comb begin
    phase_next           = phase;
    event_open_next      = event_open;
    open_hits_next       = open_hits;
    open_energy_next     = open_energy;
    open_z_next          = open_z;
    prev_z_next          = prev_z;
    closed_planes_next   = closed_planes;
    hits_so_far_next     = hits_so_far;
    energy_so_far_next   = energy_so_far;
    single_run_next      = single_run;
    gap_seen_next        = gap_seen;
    gap_plane_next       = gap_plane;
    hits_before_gap_next = hits_before_gap;
    push                 = 1'b0;
    push_rec             = close_rec;

    // The close of the open plane, used on a new plane and after the last hit.
    if ((phase == PH_HIT && in_fire && !joins && event_open) ||
        (phase == PH_CLOSE && space)) begin
      push = 1'b1;
      if (gap_found) begin
        gap_seen_next        = 1'b1;
        gap_plane_next       = closed_planes;
        hits_before_gap_next = hits_so_far;
      end
      single_run_next    = (open_hits == CNT_ONE) ? sat_add(single_run, CNT_ONE) : '0;
      energy_so_far_next = total_sum[TOT_E_W] ? {TOT_E_W{1'b1}} : total_sum[TOT_E_W-1:0];
      hits_so_far_next   = sat_add(hits_so_far, open_hits);
      closed_planes_next = sat_add(closed_planes, CNT_ONE);
      prev_z_next        = open_z;
    end

    case (phase)
      PH_HIT: begin
        if (in_fire) begin
          if (joins) begin
            open_hits_next   = sat_add(open_hits, CNT_ONE);
            open_energy_next = plane_sum[PLANE_E_W] ? {PLANE_E_W{1'b1}}
                                                    : plane_sum[PLANE_E_W-1:0];
          end else begin
            open_hits_next   = CNT_ONE;
            open_energy_next = PLANE_E_W'(hit_energy);
            event_open_next  = 1'b1;
          end
          open_z_next = hit_z;
          if (s_axis_tlast) begin
            phase_next = PH_CLOSE;
          end
        end
      end
      PH_CLOSE: begin
        if (space) begin
          phase_next = PH_SUM;
        end
      end
      PH_SUM: begin
        if (space) begin
          push                 = 1'b1;
          push_rec             = sum_rec;
          phase_next           = PH_HIT;
          event_open_next      = 1'b0;
          open_hits_next       = '0;
          open_energy_next     = '0;
          open_z_next          = '0;
          prev_z_next          = '0;
          closed_planes_next   = '0;
          hits_so_far_next     = '0;
          energy_so_far_next   = '0;
          single_run_next      = '0;
          gap_seen_next        = 1'b0;
          gap_plane_next       = '0;
          hits_before_gap_next = '0;
        end
      end
      default: begin
        phase_next = PH_HIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HIT;
      event_open      <= 1'b0;
      open_hits       <= '0;
      open_energy     <= '0;
      open_z          <= '0;
      prev_z          <= '0;
      closed_planes   <= '0;
      hits_so_far     <= '0;
      energy_so_far   <= '0;
      single_run      <= '0;
      gap_seen        <= 1'b0;
      gap_plane       <= '0;
      hits_before_gap <= '0;
    end else begin
      phase           <= phase_next;
      event_open      <= event_open_next;
      open_hits       <= open_hits_next;
      open_energy     <= open_energy_next;
      open_z          <= open_z_next;
      prev_z          <= prev_z_next;
      closed_planes   <= closed_planes_next;
      hits_so_far     <= hits_so_far_next;
      energy_so_far   <= energy_so_far_next;
      single_run      <= single_run_next;
      gap_seen        <= gap_seen_next;
      gap_plane       <= gap_plane_next;
      hits_before_gap <= hits_before_gap_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tol   <= TOL_RESET;
      piece <= PIECE_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_PLANE_TOLERANCE: tol   <= cfg_data[TOL_W-1:0];
        REG_PIECE_LENGTH:    piece <= cfg_data[PIECE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign pop = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      tail  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        tail <= ~tail;
      end
      if (pop) begin
        head <= ~head;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[tail] <= push_rec;
    end
  end

  record_t out_rec;

  assign out_rec       = q[head];
  assign m_axis_tvalid = (count != 2'd0);
  assign m_axis_tuser  = out_rec.record_kind;
  assign m_axis_tlast  = out_rec.last;
  assign m_axis_tdata  = {1'b0,
                          out_rec.all_single,
                          out_rec.trailing_single_planes,
                          out_rec.excluded_planes,
                          out_rec.pre_gap_hits,
                          out_rec.total_energy,
                          out_rec.plane_count,
                          out_rec.total_hits,
                          out_rec.plane_z,
                          out_rec.plane_energy,
                          out_rec.plane_hits};

endmodule

@@ rtl/dphg_checker.sv @@
// Port-level assertions for the detector plane hit grouper, bound to its top level.
module dphg_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [dphg_pkg::OUT_W-1:0] m_axis_tdata,
  input logic                       m_axis_tuser,
  input logic                       m_axis_tlast
);
  import dphg_pkg::*;

  a_last_is_summary: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser))
    else $error("tlast and record kind disagree");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled item changed");

  a_plane_fields_only: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[175:77] == '0))
    else $error("plane record carries event fields");

  a_summary_fields_only: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[76:0] == '0))
    else $error("summary record carries plane fields");

  a_excl_cap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[160:156] < 5'(CHECK_CAP)))
    else $error("excluded plane count above its cap");

endmodule

bind detector_plane_hit_grouper_core dphg_checker u_dphg_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
